// ===== rtl/dns_query_to_fixed_answer_macros.svh =====
// assertion macros shared by the dns responder checks
`ifndef DNS_QUERY_TO_FIXED_ANSWER_MACROS_SVH
`define DNS_QUERY_TO_FIXED_ANSWER_MACROS_SVH

// same-cycle implication, quiet during reset
`define DQFA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dqfa check failed");

// next-cycle implication, quiet during reset
`define DQFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dqfa check failed");

// next-cycle implication that also holds across reset
`define DQFA_ASSERT_RST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dqfa reset check failed");

`endif

// ===== rtl/dqfa_pkg.sv =====
// shared constants and types of the dns responder
`default_nettype none
package dqfa_pkg;

  localparam int BUFFER_BYTES = 512;
  localparam int POS_W        = $clog2(BUFFER_BYTES);
  localparam int POS_LIMIT    = BUFFER_BYTES - 17;
  localparam int HDR_BYTES    = 12;
  localparam int BURST_MAX    = 17;
  localparam int IDX_W        = $clog2(BURST_MAX);

  localparam logic [7:0] FLAGS_HI = 8'h85;
  localparam logic [7:0] FLAGS_LO = 8'h80;
  localparam logic [7:0] PTR_HI   = 8'hC0;
  localparam logic [7:0] PTR_LO   = 8'h0C;
  localparam logic [7:0] ONE_LO   = 8'h01;
  localparam logic [7:0] RDLEN_LO = 8'h04;

  localparam logic [31:0] IPV4_RESET = 32'hC0A8_0401;
  localparam logic [31:0] TTL_RESET  = 32'd60;

  localparam logic CFG_IPV4 = 1'b0;
  localparam logic CFG_TTL  = 1'b1;

  // one response burst, handed from the parser to the emitter
  typedef struct packed {
    logic       load;
    logic       is_hdr;
    logic       answer;
    logic       abort;
    logic [7:0] data;
  } burst_t;

endpackage
`default_nettype wire

// ===== rtl/dqfa_in_if.sv =====
// query byte channel
`default_nettype none
interface dqfa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/dqfa_out_if.sv =====
// response byte channel
`default_nettype none
interface dqfa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_abort;

  modport source (output valid, output out_byte, output out_last, output out_abort,
                  input ready);
  modport sink (input valid, input out_byte, input out_last, input out_abort,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/dqfa_emit.sv =====
// response burst sequencer: one response beat per cycle while reply ready is high
`default_nettype none
module dqfa_emit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dqfa_pkg::burst_t burst,
  input  wire logic [31:0]     kept,
  input  wire logic [31:0]     answer_ipv4,
  input  wire logic [31:0]     answer_ttl,
  output logic                 take,
  dqfa_out_if.source           reply
);

  logic                       active;
  logic                       is_hdr;
  logic                       with_ans;
  logic                       with_abt;
  logic [7:0]                 data;
  logic [dqfa_pkg::IDX_W-1:0] idx;
  logic [dqfa_pkg::IDX_W-1:0] last_idx;
  logic [dqfa_pkg::IDX_W-1:0] a;
  logic                       at_end;

  assign at_end = (idx == last_idx);
  assign take   = !active || (at_end && reply.ready);
  assign reply.valid = active;
  assign a = idx - dqfa_pkg::IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (burst.load) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (active && reply.ready) begin
      if (at_end) begin
        active <= 1'b0;
      end else begin
        idx <= idx + dqfa_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (burst.load) begin
      is_hdr   <= burst.is_hdr;
      with_ans <= burst.answer;
      with_abt <= burst.abort;
      data     <= burst.data;
      if (burst.is_hdr) begin
        last_idx <= dqfa_pkg::IDX_W'(dqfa_pkg::HDR_BYTES - 1) + dqfa_pkg::IDX_W'(burst.abort);
      end else if (burst.answer) begin
        last_idx <= dqfa_pkg::IDX_W'(dqfa_pkg::BURST_MAX - 1);
      end else begin
        last_idx <= dqfa_pkg::IDX_W'(burst.abort);
      end
    end
  end

  always_comb begin
    reply.out_byte  = 8'h00;
    reply.out_last  = 1'b0;
    reply.out_abort = 1'b0;
    if (is_hdr) begin
      case (idx)
        5'd0:    reply.out_byte = kept[31:24];
        5'd1:    reply.out_byte = kept[23:16];
        5'd2:    reply.out_byte = dqfa_pkg::FLAGS_HI;
        5'd3:    reply.out_byte = dqfa_pkg::FLAGS_LO;
        5'd4:    reply.out_byte = kept[15:8];
        5'd5:    reply.out_byte = kept[7:0];
        5'd7:    reply.out_byte = dqfa_pkg::ONE_LO;
        5'd12: begin
          reply.out_last  = 1'b1;
          reply.out_abort = 1'b1;
        end
        default: reply.out_byte = 8'h00;
      endcase
    end else if (idx == '0) begin
      reply.out_byte = data;
    end else if (with_ans) begin
      case (a)
        5'd0:    reply.out_byte = dqfa_pkg::PTR_HI;
        5'd1:    reply.out_byte = dqfa_pkg::PTR_LO;
        5'd3:    reply.out_byte = dqfa_pkg::ONE_LO;
        5'd5:    reply.out_byte = dqfa_pkg::ONE_LO;
        5'd6:    reply.out_byte = answer_ttl[31:24];
        5'd7:    reply.out_byte = answer_ttl[23:16];
        5'd8:    reply.out_byte = answer_ttl[15:8];
        5'd9:    reply.out_byte = answer_ttl[7:0];
        5'd11:   reply.out_byte = dqfa_pkg::RDLEN_LO;
        5'd12:   reply.out_byte = answer_ipv4[31:24];
        5'd13:   reply.out_byte = answer_ipv4[23:16];
        5'd14:   reply.out_byte = answer_ipv4[15:8];
        5'd15: begin
          reply.out_byte = answer_ipv4[7:0];
          reply.out_last = 1'b1;
        end
        default: reply.out_byte = 8'h00;
      endcase
    end else begin
      // abort mark after a cut-short question or at the buffer limit
      reply.out_last  = with_abt;
      reply.out_abort = with_abt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dns_query_to_fixed_answer.sv =====
// dns query to fixed a-record answer responder, top level
// the first response beat of an input beat is offered the cycle after the input beat is taken
// a header-completing beat gives 12 or 13 beats, a question byte 1, 2 or 17 beats
// throughput, while reply ready is high: one response beat per cycle; query ready stays low
// while a burst drains, so bytes that cause one beat each flow at one per cycle with no gap
// reset (rst, synchronous, active high) clears parser and sequencer state and loads the
// default address 192.168.4.1 and ttl 60; the kept header bytes have no reset
`default_nettype none
module dns_query_to_fixed_answer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  dqfa_in_if.sink          query,
  dqfa_out_if.source       reply
);

  // parse phase codes; unused codes act as the drop phase
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_LABEL  = 3'd2;
  localparam logic [2:0] PH_TAIL   = 3'd3;
  localparam logic [2:0] PH_DROP   = 3'd4;

  localparam int POS_W = dqfa_pkg::POS_W;

  // configuration registers
  logic [31:0] answer_ipv4;
  logic [31:0] answer_ttl;

  // parser state
  logic [2:0]       phase, phase_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [7:0]       label_left, label_next;
  logic [2:0]       tail_left, tail_next;
  logic [7:0]       lbl_dec;
  logic [2:0]       tail_dec;
  logic             complete;
  logic             end_pkt;

  // id and qdcount bytes, written by each header before they are read
  logic [7:0] kept_header [4];
  logic [31:0] kept;

  logic             in_fire;
  logic             take;
  dqfa_pkg::burst_t burst;

  assign query.ready = take;
  assign in_fire     = query.valid && query.ready;
  assign kept = {kept_header[0], kept_header[1], kept_header[2], kept_header[3]};

  assign lbl_dec  = label_left - 8'(label_left != 8'd0);
  assign tail_dec = tail_left - 3'(tail_left != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      answer_ipv4 <= dqfa_pkg::IPV4_RESET;
      answer_ttl  <= dqfa_pkg::TTL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dqfa_pkg::CFG_IPV4: answer_ipv4 <= cfg_data;
        dqfa_pkg::CFG_TTL:  answer_ttl  <= cfg_data;
        default: ;
      endcase
    end
  end

  // header bytes kept for the response
  always_ff @(posedge clk) begin
    if (in_fire && phase == PH_HEADER) begin
      if (pos == POS_W'(0)) kept_header[0] <= query.in_byte;
      if (pos == POS_W'(1)) kept_header[1] <= query.in_byte;
      if (pos == POS_W'(4)) kept_header[2] <= query.in_byte;
      if (pos == POS_W'(5)) kept_header[3] <= query.in_byte;
    end
  end

  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    label_next = label_left;
    tail_next  = tail_left;
    burst      = '0;
    complete   = 1'b0;
    end_pkt    = 1'b0;
    if (in_fire) begin
      unique case (phase)
        PH_HEADER: begin
          if (pos >= POS_W'(dqfa_pkg::HDR_BYTES - 1)) begin
            // twelfth byte: whole rewritten header goes out
            burst.load   = 1'b1;
            burst.is_hdr = 1'b1;
            burst.abort  = query.in_last;
            if (query.in_last) begin
              end_pkt = 1'b1;
            end else begin
              phase_next = PH_LEN;
              pos_next   = POS_W'(dqfa_pkg::HDR_BYTES);
            end
          end else if (query.in_last) begin
            // short packet, nothing sent
            pos_next = '0;
          end else begin
            pos_next = pos + POS_W'(1);
          end
        end
        PH_LEN, PH_LABEL, PH_TAIL: begin
          burst.load = 1'b1;
          burst.data = query.in_byte;
          if (phase == PH_LEN) begin
            if (query.in_byte == 8'd0) begin
              phase_next = PH_TAIL;
              tail_next  = 3'd4;
            end else begin
              phase_next = PH_LABEL;
              label_next = query.in_byte;
            end
          end else if (phase == PH_LABEL) begin
            label_next = lbl_dec;
            if (lbl_dec == 8'd0) phase_next = PH_LEN;
          end else begin
            tail_next = tail_dec;
            complete  = (tail_dec == 3'd0);
          end
          if (complete) begin
            burst.answer = 1'b1;
            end_pkt      = 1'b1;
          end else if (query.in_last || pos >= POS_W'(dqfa_pkg::POS_LIMIT)) begin
            // question cut short or buffer limit reached
            burst.abort = 1'b1;
            end_pkt     = 1'b1;
          end else begin
            pos_next = pos + POS_W'(1);
          end
        end
        default: begin
          // drop phase: wait for the end of the packet
          if (query.in_last) end_pkt = 1'b1;
        end
      endcase
      if (end_pkt) begin
        phase_next = query.in_last ? PH_HEADER : PH_DROP;
        pos_next   = '0;
        label_next = '0;
        tail_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      pos        <= '0;
      label_left <= '0;
      tail_left  <= '0;
    end else begin
      phase      <= phase_next;
      pos        <= pos_next;
      label_left <= label_next;
      tail_left  <= tail_next;
    end
  end

  // burst sequencer and result register
  dqfa_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .burst       (burst),
    .kept        (kept),
    .answer_ipv4 (answer_ipv4),
    .answer_ttl  (answer_ttl),
    .take        (take),
    .reply       (reply)
  );

endmodule
`default_nettype wire

// ===== rtl/dqfa_checker.sv =====
// port-level checks for the dns responder, bound to the top level
`default_nettype none
`include "dns_query_to_fixed_answer_macros.svh"
module dqfa_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last,
  input wire logic       out_abort
);

  // abort mark is a zero byte that closes the response
  `DQFA_ASSERT_NOW(abort_is_mark, out_valid && out_abort, out_last && out_byte == 8'h00)

  // a new query beat is only taken when the pending response beat leaves
  `DQFA_ASSERT_NOW(take_only_on_drain, in_ready && out_valid, out_ready)

  // stalled response beat holds
  `DQFA_ASSERT_NEXT(out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_byte) && $stable(out_last) && $stable(out_abort))

  // nothing offered right after reset
  `DQFA_ASSERT_RST_NEXT(quiet_after_reset, rst, !out_valid)

endmodule

bind dns_query_to_fixed_answer dqfa_checker u_dqfa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (query.ready),
  .out_valid (reply.valid),
  .out_ready (reply.ready),
  .out_byte  (reply.out_byte),
  .out_last  (reply.out_last),
  .out_abort (reply.out_abort)
);
`default_nettype wire

// ===== dv/tb.sv =====
// self-checking testbench for the dns query to fixed answer responder
`timescale 1ns / 1ps
module tb;

  // how a stimulus row states its expected reply
  typedef enum logic [1:0] {
    RK_SILENT,   // no reply beat at all
    RK_ECHO,     // one beat carrying the query byte back
    RK_MODEL     // whatever the predictor works out
  } row_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    row_kind_t  kind;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       abort;
  } reply_beat_t;

  // parser phases of the predictor
  typedef enum logic [2:0] {
    QP_HEADER,
    QP_LEN,
    QP_LABEL,
    QP_TAIL,
    QP_DROP
  } qphase_t;

  localparam int STALL_LIMIT = 2000;  // cycles with no beat on either side
  localparam int CFG_SETTLE  = 4;     // quiet cycles before a register write
  localparam int END_SETTLE  = 20;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  dqfa_in_if  query_ch ();
  dqfa_out_if reply_ch ();

  dns_query_to_fixed_answer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .query     (query_ch),
    .reply     (reply_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: its own copy of the parser and of the answer registers
  // ---------------------------------------------------------------------------
  logic [31:0]                ans_ipv4   = dqfa_pkg::IPV4_RESET;
  logic [31:0]                ans_ttl    = dqfa_pkg::TTL_RESET;
  logic [7:0]                 hdr_keep [4];  // id and qdcount, written before use
  logic [dqfa_pkg::POS_W-1:0] qpos       = '0;
  logic [7:0]                 label_left = '0;
  logic [2:0]                 tail_left  = '0;
  qphase_t                    qp         = QP_HEADER;

  reply_beat_t burst_beats [$];   // beats caused by the latest query beat
  reply_beat_t reply_due [$];     // reply beats still to arrive, oldest first
  stim_row_t   pkt_q [$];         // query packet being built

  int mismatches   = 0;
  int reply_count  = 0;
  int stall_cycles = 0;
  bit src_idle_on  = 1'b1;
  bit sink_idle_on = 1'b1;

  function automatic void push_beat(input logic [7:0] d, input logic l, input logic a);
    burst_beats.push_back('{data: d, last: l, abort: a});
  endfunction

  // packet over: back to the header on its final byte, else discard until it
  function automatic void close_packet(input logic l);
    qp         = l ? QP_HEADER : QP_DROP;
    qpos       = '0;
    label_left = '0;
    tail_left  = '0;
  endfunction

  // works out the reply beats of one query beat and moves the parser on
  function automatic void predict_reply(input logic [7:0] b, input logic l);
    logic       done;
    logic [7:0] hdr_out [12];
    logic [7:0] ans_out [16];
    done = 1'b0;
    burst_beats.delete();
    case (qp)
      QP_HEADER: begin
        case (qpos)
          dqfa_pkg::POS_W'(0): hdr_keep[0] = b;
          dqfa_pkg::POS_W'(1): hdr_keep[1] = b;
          dqfa_pkg::POS_W'(4): hdr_keep[2] = b;
          dqfa_pkg::POS_W'(5): hdr_keep[3] = b;
          default: ;
        endcase
        if (qpos >= dqfa_pkg::HDR_BYTES - 1) begin
          hdr_out = '{hdr_keep[0], hdr_keep[1], dqfa_pkg::FLAGS_HI, dqfa_pkg::FLAGS_LO,
                      hdr_keep[2], hdr_keep[3], 8'h00, dqfa_pkg::ONE_LO,
                      8'h00, 8'h00, 8'h00, 8'h00};
          foreach (hdr_out[k]) push_beat(hdr_out[k], 1'b0, 1'b0);
          if (l) begin
            // header only: abort mark straight after the header
            push_beat(8'h00, 1'b1, 1'b1);
            close_packet(1'b1);
          end else begin
            qp   = QP_LEN;
            qpos = dqfa_pkg::POS_W'(dqfa_pkg::HDR_BYTES);
          end
        end else if (l) begin
          qpos = '0;   // short packet, nothing sent
        end else begin
          qpos = qpos + dqfa_pkg::POS_W'(1);
        end
      end
      QP_LEN, QP_LABEL, QP_TAIL: begin
        push_beat(b, 1'b0, 1'b0);
        if (qp == QP_LEN) begin
          if (b == 8'h00) begin
            qp        = QP_TAIL;
            tail_left = 3'd4;
          end else begin
            // any nonzero length skips that many bytes, pointers included
            qp         = QP_LABEL;
            label_left = b;
          end
        end else if (qp == QP_LABEL) begin
          if (label_left != 8'h00) label_left = label_left - 8'd1;
          if (label_left == 8'h00) qp = QP_LEN;
        end else begin
          if (tail_left != 3'd0) tail_left = tail_left - 3'd1;
          if (tail_left == 3'd0) done = 1'b1;
        end
        if (done) begin
          ans_out = '{dqfa_pkg::PTR_HI, dqfa_pkg::PTR_LO, 8'h00, dqfa_pkg::ONE_LO,
                      8'h00, dqfa_pkg::ONE_LO,
                      ans_ttl[31:24], ans_ttl[23:16], ans_ttl[15:8], ans_ttl[7:0],
                      8'h00, dqfa_pkg::RDLEN_LO,
                      ans_ipv4[31:24], ans_ipv4[23:16], ans_ipv4[15:8], ans_ipv4[7:0]};
          foreach (ans_out[k]) push_beat(ans_out[k], k == 15, 1'b0);
          close_packet(l);
        end else if (l || qpos >= dqfa_pkg::POS_LIMIT) begin
          // question cut short or out of buffer room
          push_beat(8'h00, 1'b1, 1'b1);
          close_packet(l);
        end else begin
          qpos = qpos + dqfa_pkg::POS_W'(1);
        end
      end
      default: if (l) close_packet(1'b1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // query side
  // ---------------------------------------------------------------------------
  // offers one beat, waits for the handshake, then books its reply
  task automatic send_beat(input stim_row_t row);
    while (src_idle_on && $urandom_range(0, 99) < 16) begin
      query_ch.valid <= 1'b0;
      @(posedge clk);
    end
    query_ch.valid   <= 1'b1;
    query_ch.in_byte <= row.data;
    query_ch.in_last <= row.last;
    do @(posedge clk); while (!query_ch.ready);
    predict_reply(row.data, row.last);
    case (row.kind)
      RK_SILENT: ;
      RK_ECHO:   reply_due.push_back('{data: row.data, last: 1'b0, abort: 1'b0});
      default:   foreach (burst_beats[k]) reply_due.push_back(burst_beats[k]);
    endcase
  endtask

  // holds the query side until every booked reply beat has come
  task automatic wait_replies();
    query_ch.valid <= 1'b0;
    while (reply_due.size() != 0) @(posedge clk);
  endtask

  task automatic settle_for_config();
    wait_replies();
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  // both answer registers, one write each on back-to-back edges
  task automatic load_answer(input logic [31:0] ipv4, input logic [31:0] ttl);
    cfg_we    <= 1'b1;
    cfg_index <= dqfa_pkg::CFG_IPV4;
    cfg_data  <= ipv4;
    @(posedge clk);
    cfg_index <= dqfa_pkg::CFG_TTL;
    cfg_data  <= ttl;
    @(posedge clk);
    cfg_we   <= 1'b0;
    ans_ipv4 = ipv4;
    ans_ttl  = ttl;
  endtask

  function automatic void add_query_byte(input logic [7:0] d);
    pkt_q.push_back('{data: d, last: 1'b0, kind: RK_MODEL});
  endfunction

  // well-formed query: random header, labels, root, qtype/qclass, junk after
  function automatic void build_query(input int n_labels, input int big_len,
                                      input int trailing);
    int len;
    pkt_q.delete();
    repeat (dqfa_pkg::HDR_BYTES) add_query_byte(8'($urandom_range(0, 255)));
    for (int i = 0; i < n_labels; i++) begin
      len = (big_len > 0) ? big_len : $urandom_range(1, 6);
      add_query_byte(8'(len));
      repeat (len) add_query_byte(8'($urandom_range(0, 255)));
    end
    add_query_byte(8'h00);
    repeat (4 + trailing) add_query_byte(8'($urandom_range(0, 255)));
    pkt_q[$].last = 1'b1;
  endfunction

  // truncates the packet to its first keep bytes
  function automatic void cut_packet(input int keep);
    while (pkt_q.size() > keep) void'(pkt_q.pop_back());
    pkt_q[$].last = 1'b1;
  endfunction

  // pause_at: index of the beat before which the sender waits for all replies
  task automatic send_packet(input int pause_at);
    foreach (pkt_q[i]) begin
      if (i == pause_at) wait_replies();
      send_beat(pkt_q[i]);
    end
  endtask

  // random packets, mostly well-formed, until about budget bytes have gone in
  task automatic run_random(input int budget);
    int sent;
    int pick;
    int trail;
    int labels;
    sent = 0;
    while (sent < budget) begin
      pick   = $urandom_range(0, 99);
      trail  = $urandom_range(0, 2);
      labels = $urandom_range(0, 3);
      build_query(labels, 0, trail);
      if (pick >= 82)
        cut_packet($urandom_range(dqfa_pkg::HDR_BYTES + 1, pkt_q.size() - 1 - trail));
      else if (pick >= 74)
        cut_packet(dqfa_pkg::HDR_BYTES);
      else if (pick >= 62)
        cut_packet($urandom_range(1, dqfa_pkg::HDR_BYTES - 1));
      sent += pkt_q.size();
      send_packet(-1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // reply side: random back-pressure and the beat check
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    reply_beat_t due;
    if (rst) begin
      reply_ch.ready <= 1'b0;
    end else begin
      if (reply_ch.valid && reply_ch.ready) begin
        if (reply_due.size() == 0) begin
          report_mismatch($sformatf("reply beat %0d with nothing expected (byte %02h)",
                                    reply_count, reply_ch.out_byte));
        end else begin
          due = reply_due.pop_front();
          if (reply_ch.out_byte !== due.data)
            report_mismatch($sformatf("reply beat %0d: out_byte %02h, expected %02h",
                                      reply_count, reply_ch.out_byte, due.data));
          if (reply_ch.out_last !== due.last)
            report_mismatch($sformatf("reply beat %0d: out_last %b, expected %b",
                                      reply_count, reply_ch.out_last, due.last));
          if (reply_ch.out_abort !== due.abort)
            report_mismatch($sformatf("reply beat %0d: out_abort %b, expected %b",
                                      reply_count, reply_ch.out_abort, due.abort));
        end
        reply_count++;
      end
      reply_ch.ready <= !(sink_idle_on && $urandom_range(0, 99) < 16);
    end
  end

  // watchdog: too long with no beat accepted on either side
  always @(posedge clk) begin
    if (rst || (query_ch.valid && query_ch.ready) || (reply_ch.valid && reply_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("dns_query_to_fixed_answer test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed rows, run with the reset answer registers
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows [22] = '{
    // short packet: ends well inside the header, no reply
    '{8'hFF, 1'b0, RK_SILENT}, '{8'h00, 1'b1, RK_SILENT},
    // header: id ff 00, flags, qdcount 80 7f, counts; nothing until the twelfth byte
    '{8'hFF, 1'b0, RK_SILENT}, '{8'h00, 1'b0, RK_SILENT}, '{8'h12, 1'b0, RK_SILENT},
    '{8'h34, 1'b0, RK_SILENT}, '{8'h80, 1'b0, RK_SILENT}, '{8'h7F, 1'b0, RK_SILENT},
    '{8'h55, 1'b0, RK_SILENT}, '{8'hAA, 1'b0, RK_SILENT}, '{8'h01, 1'b0, RK_SILENT},
    '{8'h02, 1'b0, RK_SILENT}, '{8'h03, 1'b0, RK_SILENT}, '{8'h04, 1'b0, RK_MODEL},
    // qname: one label of a single ff byte, then the root
    '{8'h01, 1'b0, RK_ECHO}, '{8'hFF, 1'b0, RK_ECHO}, '{8'h00, 1'b0, RK_ECHO},
    // qtype a, qclass in; answer follows the last qclass byte
    '{8'h00, 1'b0, RK_ECHO}, '{8'h01, 1'b0, RK_ECHO}, '{8'h00, 1'b0, RK_ECHO},
    '{8'h01, 1'b0, RK_MODEL},
    // trailing record byte is dropped
    '{8'h9C, 1'b1, RK_SILENT}
  };

  initial begin
    query_ch.valid   <= 1'b0;
    query_ch.in_byte <= 8'h00;
    query_ch.in_last <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= dqfa_pkg::CFG_IPV4;
    cfg_data         <= 32'h0;
    rst              <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset address and ttl
    foreach (dir_rows[i]) send_beat(dir_rows[i]);
    run_random(40);

    // all-zero registers, no idling on either side for the whole phase
    settle_for_config();
    load_answer(32'h0000_0000, 32'h0000_0000);
    src_idle_on  <= 1'b0;
    sink_idle_on <= 1'b0;
    build_query(2, 0, 1);
    send_packet(dqfa_pkg::HDR_BYTES + 2);   // sender holds mid-question until replies drain
    run_random(30);

    // all-ones registers, labels of c0 and above, question runs out of buffer room
    // and the packet ends a few bytes into the drop phase
    settle_for_config();
    src_idle_on  <= 1'b1;
    sink_idle_on <= 1'b1;
    load_answer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    build_query(3, $urandom_range(192, 255), 0);
    cut_packet(dqfa_pkg::POS_LIMIT + 3);
    send_packet(-1);
    run_random(20);

    // random registers
    settle_for_config();
    load_answer($urandom, $urandom);
    run_random(40);

    wait_replies();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("dns_query_to_fixed_answer test passed");
    else
      $display("dns_query_to_fixed_answer test failed");
    $finish;
  end

endmodule
